@@ sv/dsf_pkg.sv @@
package dsf_pkg;

  localparam int unsigned CharWidth       = 16;
  localparam int unsigned PatternWidth    = 64;
  localparam int unsigned LengthWidth     = 3;
  localparam int unsigned MaxDelimChars   = 4;
  localparam int unsigned PosWidthDefault = 16;
  localparam int unsigned CfgIndexWidth   = 2;

  // Configuration register indexes.
  localparam logic [CfgIndexWidth-1:0] CfgBeginPattern = 2'd0;
  localparam logic [CfgIndexWidth-1:0] CfgBeginLength  = 2'd1;
  localparam logic [CfgIndexWidth-1:0] CfgEndPattern   = 2'd2;
  localparam logic [CfgIndexWidth-1:0] CfgEndLength    = 2'd3;

  // Picks character idx of a packed delimiter, first character in the low bits.
  function automatic logic [CharWidth-1:0] delim_char(
    input logic [PatternWidth-1:0] pattern,
    input logic [1:0]              idx
  );
    return pattern[idx*CharWidth +: CharWidth];
  endfunction

  // Clamps a programmed length into 1..MaxDelimChars.
  function automatic logic [LengthWidth-1:0] used_length(input logic [LengthWidth-1:0] len);
    logic [LengthWidth-1:0] max_len;
    max_len = LengthWidth'(MaxDelimChars);
    if (len == '0) begin
      return LengthWidth'(1);
    end else if (len > max_len) begin
      return max_len;
    end
    return len;
  endfunction

endpackage

@@ sv/delimited_span_finder_core.sv @@
// Delimiter span finder. A string streams in one 16-bit character per beat,
// with tlast on its last character. The block finds the first span that opens
// with the programmed begin delimiter and closes with the programmed end
// delimiter (each one to four characters) and returns exactly one result beat
// per input beat: tuser marks the beat that completes the first span, and tdata
// then carries the 1-based positions of the span's first and last characters
// (zero otherwise). Matching is a plain four-phase scan: a mismatch while
// reading a delimiter falls back one phase without re-examining the current
// character, and the character that completes the begin delimiter may also
// open the end delimiter. After a match the rest of the string is ignored;
// the tlast beat is echoed and clears the scan state for the next string.
// Throughput is one character per clock while the result stream is not
// stalled: the whole phase update is a few 16-bit compares and one position
// subtract, done between the input register and the result register. An
// input register and the result register let the block take a new beat
// while a finished result is still waiting to be taken. Configuration
// writes are always accepted and should be made between strings.
module delimited_span_finder_core
  import dsf_pkg::*;
#(
  parameter int unsigned POS_WIDTH = PosWidthDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,

  // Configuration write channel.
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIndexWidth-1:0] cfg_index_i,
  input  logic [PatternWidth-1:0]  cfg_data_i,

  // Character stream.
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [CharWidth-1:0]     s_axis_tdata,   // [15:0] character
  input  logic                     s_axis_tlast,   // is_final

  // Result stream.
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [2*CharWidth-1:0]   m_axis_tdata,   // [15:0] span_start, [31:16] span_end
  output logic                     m_axis_tuser,   // [0] match_found
  output logic                     m_axis_tlast    // string_done
);

  typedef enum logic [1:0] {
    SeekBegin,
    ReadBegin,
    SeekEnd,
    ReadEnd
  } phase_e;

  // Positions are reported as their low 16 bits, zero-extended if narrower.
  localparam int unsigned WideWidth = (POS_WIDTH > CharWidth) ? POS_WIDTH : CharWidth;

  // Configuration registers.
  logic [PatternWidth-1:0] begin_pattern_q;
  logic [LengthWidth-1:0]  begin_length_q;
  logic [PatternWidth-1:0] end_pattern_q;
  logic [LengthWidth-1:0]  end_length_q;

  // Input register.
  logic                    in_valid_q;
  logic [CharWidth-1:0]    in_char_q;
  logic                    in_last_q;

  // Scan state.
  phase_e                  phase_q, phase_d;
  logic [POS_WIDTH-1:0]    pos_q, pos_d;
  logic [POS_WIDTH-1:0]    anchor_q, anchor_d;
  logic [POS_WIDTH-1:0]    span_q, span_d;
  logic                    matched_q, matched_d;

  // Result register.
  logic                    out_valid_q;
  logic [2*CharWidth-1:0]  out_data_q;
  logic                    out_found_q;
  logic                    out_last_q;

  logic                    advance;
  logic                    found;
  logic [POS_WIDTH-1:0]    blen_ext, elen_ext;
  logic [POS_WIDTH-1:0]    offs_b, k_b, offs_e, k_e;
  logic [WideWidth-1:0]    start_wide, end_wide;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      begin_pattern_q <= '0;
      begin_length_q  <= LengthWidth'(1);
      end_pattern_q   <= '0;
      end_length_q    <= LengthWidth'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgBeginPattern: begin_pattern_q <= cfg_data_i;
        CfgBeginLength:  begin_length_q  <= cfg_data_i[LengthWidth-1:0];
        CfgEndPattern:   end_pattern_q   <= cfg_data_i;
        CfgEndLength:    end_length_q    <= cfg_data_i[LengthWidth-1:0];
        default: ;
      endcase
    end
  end

  // The result register moves when it is empty or being drained; the input
  // register then moves with it, or fills whenever it is empty.
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  assign blen_ext = POS_WIDTH'(used_length(begin_length_q));
  assign elen_ext = POS_WIDTH'(used_length(end_length_q));

  // One character of the four-phase scan. The phases are tested in order so
  // that a single character can move through several of them in one step.
  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    anchor_d  = anchor_q;
    span_d    = span_q;
    matched_d = matched_q;
    found     = 1'b0;
    offs_b    = '0;
    k_b       = '0;
    offs_e    = '0;
    k_e       = '0;

    if (!matched_q) begin
      pos_d = pos_q + 1'b1;

      if (phase_d == SeekBegin && in_char_q == delim_char(begin_pattern_q, 2'd0)) begin
        anchor_d = pos_d;
        span_d   = pos_d;
        phase_d  = ReadBegin;
      end

      if (phase_d == ReadBegin) begin
        offs_b = pos_d - anchor_d;
        k_b    = offs_b + 1'b1;
        if (k_b < blen_ext) begin
          if (in_char_q != delim_char(begin_pattern_q, offs_b[1:0])) begin
            phase_d = SeekBegin;
          end
        end else if (k_b == blen_ext) begin
          phase_d = (in_char_q == delim_char(begin_pattern_q, offs_b[1:0])) ? SeekEnd
                                                                             : SeekBegin;
        end
      end

      if (phase_d == SeekEnd && in_char_q == delim_char(end_pattern_q, 2'd0)) begin
        anchor_d = pos_d;
        phase_d  = ReadEnd;
      end

      if (phase_d == ReadEnd) begin
        offs_e = pos_d - anchor_d;
        k_e    = offs_e + 1'b1;
        if (k_e < elen_ext) begin
          if (in_char_q != delim_char(end_pattern_q, offs_e[1:0])) begin
            phase_d = SeekEnd;
          end
        end else if (k_e == elen_ext) begin
          if (in_char_q == delim_char(end_pattern_q, offs_e[1:0])) begin
            found     = 1'b1;
            matched_d = 1'b1;
          end else begin
            phase_d = SeekEnd;
          end
        end
      end
    end
  end

  assign start_wide = WideWidth'(span_d);
  assign end_wide   = WideWidth'(pos_d);

  // The tlast character returns the scan to its reset state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= SeekBegin;
      pos_q     <= '0;
      anchor_q  <= '0;
      span_q    <= '0;
      matched_q <= 1'b0;
    end else if (advance && in_valid_q) begin
      if (in_last_q) begin
        phase_q   <= SeekBegin;
        pos_q     <= '0;
        anchor_q  <= '0;
        span_q    <= '0;
        matched_q <= 1'b0;
      end else begin
        phase_q   <= phase_d;
        pos_q     <= pos_d;
        anchor_q  <= anchor_d;
        span_q    <= span_d;
        matched_q <= matched_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      out_found_q <= found;
      out_last_q  <= in_last_q;
      out_data_q  <= found ? {end_wide[CharWidth-1:0], start_wide[CharWidth-1:0]} : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_found_q;
  assign m_axis_tlast  = out_last_q;

  // A beat without a match carries zero positions.
  a_no_match_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("result without a match carries nonzero positions");

  // Once matched, the scan stays parked in the end-reading phase.
  a_matched_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    matched_q |-> (phase_q == ReadEnd))
    else $error("matched flag set outside the end-reading phase");

  // The input side only stalls when both registers are full and blocked.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled without a full, blocked pipeline");

  // A processed tlast character leaves the scan state cleared.
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_valid_q && in_last_q) |=> (pos_q == '0 && !matched_q))
    else $error("scan state not cleared after the last character");

endmodule
